/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/wss_pkg.sv */
// Shared constants and command/status types for windowed sensor statistics.
// Depends on nothing.
package wss_pkg;
    localparam int WINDOW_LEN   = 6;
    localparam int NUM_CHANNELS = 7;
    localparam int CH_W   = 3;
    localparam int POS_W  = $clog2(WINDOW_LEN + 1);
    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = 16 + $clog2(WINDOW_LEN + 1) + 1;
    localparam int MEM_DEPTH = NUM_CHANNELS * WINDOW_LEN;
    localparam int ADDR_W = $clog2(MEM_DEPTH + 1);
    localparam int SQ_W   = 34;
    localparam int ACC_W  = SQ_W + $clog2(WINDOW_LEN + 1);
    localparam int DIVB_W = (SUM_W > ACC_W) ? SUM_W : ACC_W;
    localparam int DCNT_W = $clog2(DIVB_W + 1);
    localparam int RT_W   = ACC_W / 2 + 1;
    localparam int RCNT_W = $clog2(RT_W + 1);

    typedef struct packed {
        logic start;
        logic load_sum;
        logic div_sum;
        logic div_acc;
        logic clr_acc;
        logic acc_en;
        logic sqrt_start;
        logic [IDX_W-1:0] rd_idx;
    } wss_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic done;
        logic bad_ch;
    } wss_sts_t;
endpackage

/* rtl/wss_ctrl.sv */
// Sequencer for windowed sensor statistics: input/output handshake and steps.
// Depends on wss_pkg.
module wss_ctrl import wss_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  wss_sts_t sts,
    output wss_cmd_t cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_UPD, ST_MDIV, ST_RD, ST_ACC, ST_VDIV, ST_SQRT, ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             started_reg, started_next;
    logic             acc_pend_reg, acc_pend_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        started_next  = 1'b0;
        acc_pend_next = 1'b0;
        cmd           = '0;
        cmd.rd_idx    = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.load_sum = 1'b1;
                state_next   = sts.bad_ch ? ST_OUT : ST_MDIV;
            end
            ST_MDIV: begin
                if (!started_reg) begin
                    cmd.div_sum  = 1'b1;
                    started_next = 1'b1;
                end else if (!sts.div_busy) begin
                    idx_next    = '0;
                    cmd.clr_acc = 1'b1;
                    state_next  = sts.done ? ST_RD : ST_OUT;
                end else begin
                    started_next = 1'b1;
                end
            end
            ST_RD: begin
                acc_pend_next = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = acc_pend_reg;
                if (idx_reg == IDX_W'(WINDOW_LEN - 1)) begin
                    state_next = ST_VDIV;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_VDIV: begin
                if (!started_reg) begin
                    cmd.div_acc  = 1'b1;
                    started_next = 1'b1;
                end else if (!sts.div_busy) begin
                    cmd.sqrt_start = 1'b1;
                    started_next   = 1'b1;
                    state_next     = ST_SQRT;
                end else begin
                    started_next = 1'b1;
                end
            end
            ST_SQRT: begin
                if (!started_reg && !sts.sqrt_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            started_reg  <= 1'b0;
            acc_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            started_reg  <= started_next;
            acc_pend_reg <= acc_pend_next;
        end
    end
endmodule

/* rtl/wss_div.sv */
// Restoring unsigned divider by a fill count or the window length, one quotient bit per cycle.
// Depends on wss_pkg.
module wss_div import wss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVB_W-1:0] dividend,
    input  logic [POS_W-1:0]  divisor,
    output logic              busy,
    output logic [DIVB_W-1:0] quotient
);
    logic [DIVB_W-1:0] q_reg, q_next;
    logic [POS_W:0]    r_reg, r_next;
    logic [POS_W-1:0]  d_reg, d_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [POS_W:0]    trial;

    assign busy     = busy_reg;
    assign quotient = q_reg;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[POS_W-1:0], q_reg[DIVB_W-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = DCNT_W'(DIVB_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[DIVB_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[DIVB_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != DCNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

/* rtl/wss_sqrt.sv */
// Bit-pair floor square root, one root bit per cycle.
// Depends on wss_pkg.
module wss_sqrt import wss_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ACC_W-1:0] radicand,
    output logic             busy,
    output logic [15:0]      root
);
    localparam int V_W = 2 * RT_W;

    logic [V_W-1:0]    v_reg, v_next;
    logic [RT_W-1:0]   q_reg, q_next;
    logic [RT_W+1:0]   r_reg, r_next;
    logic [RCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [RT_W+1:0]   trial;
    logic [RT_W+1:0]   sub;

    assign busy = busy_reg;
    assign root = q_reg[15:0];

    always_comb begin
        v_next    = v_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[RT_W-1:0], v_reg[V_W-1 -: 2]};
        sub       = {q_reg, 2'b01};
        if (start) begin
            v_next    = V_W'(radicand);
            q_next    = '0;
            r_next    = '0;
            cnt_next  = RCNT_W'(RT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            v_next = {v_reg[V_W-3:0], 2'b00};
            if (trial >= sub) begin
                r_next = trial - sub;
                q_next = {q_reg[RT_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[RT_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != RCNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        v_reg <= v_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule

/* rtl/wss_dp.sv */
// Datapath: per-channel state, window memory, deviation accumulator, result.
// Depends on wss_pkg, wss_div, wss_sqrt.
module wss_dp import wss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CH_W-1:0]   s_channel,
    input  logic signed [15:0] s_sample,
    input  wss_cmd_t          cmd,
    output wss_sts_t          sts,
    output logic [CH_W-1:0]   m_channel_out,
    output logic signed [15:0] m_minimum,
    output logic signed [15:0] m_maximum,
    output logic signed [15:0] m_window_mean,
    output logic [15:0]       m_std_dev,
    output logic              m_window_done
);
    logic [POS_W-1:0]   fill_reg [NUM_CHANNELS];
    logic signed [SUM_W-1:0] sum_reg [NUM_CHANNELS];
    logic signed [15:0] min_reg  [NUM_CHANNELS];
    logic signed [15:0] max_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] seen_reg;
    logic signed [15:0] mem [MEM_DEPTH];

    logic [CH_W-1:0]    ch_reg;
    logic signed [15:0] smp_reg;
    logic               bad_reg;
    logic [POS_W-1:0]   pos_reg;
    logic signed [SUM_W-1:0] wsum_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [15:0] mn_reg, mx_reg, mean_reg;
    logic signed [15:0] rd_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [15:0]        sd_reg;

    logic [CH_W-1:0]    chi;
    logic [POS_W-1:0]   fpos;
    logic [POS_W-1:0]   npos;
    logic signed [SUM_W-1:0] nsum;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic               div_go;
    logic [DIVB_W-1:0]  div_a;
    logic [POS_W-1:0]   div_d;
    logic               div_busy;
    logic [DIVB_W-1:0]  div_q;
    logic               sq_busy;
    logic [15:0]        sq_root;
    logic signed [17:0] dev;
    logic [16:0]        mag;
    logic [SQ_W-1:0]    sq;

    assign chi  = ch_reg;
    assign fpos = (fill_reg[chi] >= POS_W'(WINDOW_LEN)) ? '0 : fill_reg[chi];
    assign npos = fpos + 1'b1;
    assign nsum = sum_reg[chi] + SUM_W'(smp_reg);
    assign wr_addr = ADDR_W'(chi * WINDOW_LEN) + ADDR_W'(fpos);
    assign rd_addr = ADDR_W'(chi * WINDOW_LEN) + ADDR_W'(cmd.rd_idx);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ch_reg  <= s_channel;
            smp_reg <= s_sample;
            bad_reg <= (s_channel >= CH_W'(NUM_CHANNELS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                fill_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end else if (cmd.load_sum && !bad_reg) begin
            seen_reg[chi] <= 1'b1;
            if (npos == POS_W'(WINDOW_LEN)) begin
                fill_reg[chi] <= '0;
                sum_reg[chi]  <= '0;
            end else begin
                fill_reg[chi] <= npos;
                sum_reg[chi]  <= nsum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sum) begin
            pos_reg  <= npos;
            wsum_reg <= nsum;
            neg_reg  <= nsum < 0;
            done_reg <= !bad_reg && (npos == POS_W'(WINDOW_LEN));
            sd_reg   <= '0;
            mean_reg <= '0;
            if (bad_reg) begin
                mn_reg <= '0;
                mx_reg <= '0;
            end else begin
                mem[wr_addr] <= smp_reg;
                if (!seen_reg[chi] || smp_reg < min_reg[chi]) begin
                    min_reg[chi] <= smp_reg;
                    mn_reg       <= smp_reg;
                end else begin
                    mn_reg <= min_reg[chi];
                end
                if (!seen_reg[chi] || smp_reg > max_reg[chi]) begin
                    max_reg[chi] <= smp_reg;
                    mx_reg       <= smp_reg;
                end else begin
                    mx_reg <= max_reg[chi];
                end
            end
        end else if (sts.done && !sq_busy && !cmd.sqrt_start) begin
            sd_reg <= sq_root;
        end
        rd_reg <= mem[rd_addr];
        if (cmd.clr_acc) begin
            mean_reg <= neg_reg ? -div_q[15:0] : div_q[15:0];
            acc_reg  <= '0;
        end
        if (cmd.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(sq);
        end
    end

    assign dev = 18'(rd_reg) - 18'(mean_reg);
    assign mag = dev[17] ? 17'(-dev) : dev[16:0];
    assign sq  = SQ_W'(mag) * SQ_W'(mag);

    assign div_go = cmd.div_sum || cmd.div_acc;
    assign div_a  = cmd.div_sum ? DIVB_W'(neg_reg ? -wsum_reg : wsum_reg)
                                : DIVB_W'(acc_reg);
    assign div_d  = cmd.div_sum ? pos_reg : POS_W'(WINDOW_LEN);

    wss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go),
        .dividend (div_a),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (div_q)
    );

    wss_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (div_q[ACC_W-1:0]),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    assign sts.div_busy  = div_busy;
    assign sts.sqrt_busy = sq_busy;
    assign sts.done      = done_reg;
    assign sts.bad_ch    = bad_reg;

    assign m_channel_out = ch_reg;
    assign m_minimum     = mn_reg;
    assign m_maximum     = mx_reg;
    assign m_window_mean = mean_reg;
    assign m_std_dev     = sd_reg;
    assign m_window_done = done_reg;
endmodule

/* rtl/windowed_sensor_statistics.sv */
// Windowed sensor statistics: per-channel min, max, window mean and std dev.
// One word at a time, accepted only while idle; each word on a valid channel runs the serial
// divider for the mean, and a word that closes a window adds a window walk, a second division and the square root.
// Synchronous active-low reset clears fill counts, sums and seen flags.
// Depends on wss_pkg, wss_ctrl, wss_dp.
module windowed_sensor_statistics import wss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_channel,
    input  logic signed [15:0] s_sample,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_channel_out,
    output logic signed [15:0] m_minimum,
    output logic signed [15:0] m_maximum,
    output logic signed [15:0] m_window_mean,
    output logic [15:0]       m_std_dev,
    output logic              m_window_done
);
    wss_cmd_t cmd;
    wss_sts_t sts;

    wss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wss_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .cmd           (cmd),
        .sts           (sts),
        .m_channel_out (m_channel_out),
        .m_minimum     (m_minimum),
        .m_maximum     (m_maximum),
        .m_window_mean (m_window_mean),
        .m_std_dev     (m_std_dev),
        .m_window_done (m_window_done)
    );
endmodule

/* rtl/wss_checker.sv */
// Port-level checks for windowed_sensor_statistics, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module wss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_channel_out,
    input logic signed [15:0] m_minimum,
    input logic signed [15:0] m_maximum,
    input logic signed [15:0] m_window_mean,
    input logic [15:0] m_std_dev,
    input logic        m_window_done
);
    `ASSERT_IMPL(a_one_at_a_time, aclk, aresetn, m_valid, !s_ready, "accept while result pending")
    `ASSERT_IMPL(a_sd_only_done, aclk, aresetn, m_valid && !m_window_done, m_std_dev == 16'd0, "std dev without window")
    `ASSERT_IMPL(a_min_le_max, aclk, aresetn, m_valid && m_channel_out < 3'd7, m_minimum <= m_maximum, "min above max")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_window_mean), "result dropped")
endmodule

bind windowed_sensor_statistics wss_checker u_wss_checker (.*);
